/* design/lese_pkg.sv */
// ----------------------------------------------------------------------------
// lese_pkg
// Shared types, widths and constants of the linear elastic stress and energy
// pipeline.
// ----------------------------------------------------------------------------
package lese_pkg;

    // Fixed-point format of every input, register and output value.
    localparam int FRAC_BITS = 16;

    // Field widths.
    localparam int IN_W     = 32;
    localparam int STRESS_W = 32;
    localparam int ENERGY_W = 48;
    localparam int MU_W     = 31;
    localparam int MU2_W    = MU_W + 1;
    localparam int LAMBDA_W = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Doubled strain entries and the trace of the doubled strain.
    localparam int D_W   = IN_W + 2;
    localparam int T_W   = IN_W + 3;
    // Split point for the partial products of the strain entries and trace.
    localparam int SPLIT = 17;

    // Pipeline stage indexes.
    localparam int STG_STRAIN = 0;
    localparam int STG_PROD   = 1;
    localparam int STG_MERGE  = 2;
    localparam int STG_SUM3   = 3;
    localparam int STG_SUM9   = 4;
    localparam int STG_MU     = 5;
    localparam int STG_EN1    = 6;
    localparam int STG_OUT    = 7;
    localparam int NUM_STG    = STG_OUT + 1;

    // Register reset values.
    localparam logic [MU_W-1:0]            LAME_MU_RST     = MU_W'(65536);
    localparam logic signed [LAMBDA_W-1:0] LAME_LAMBDA_RST = '0;

    // Saturation limits.
    localparam logic signed [STRESS_W-1:0] STRESS_MAX = {1'b0, {(STRESS_W-1){1'b1}}};
    localparam logic signed [STRESS_W-1:0] STRESS_MIN = {1'b1, {(STRESS_W-1){1'b0}}};
    localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAME_MU     = 1'b0,
        CFG_LAME_LAMBDA = 1'b1
    } t_cfg_idx;

    typedef logic signed [IN_W-1:0]     t_fix;
    typedef logic signed [STRESS_W-1:0] t_sval;
    typedef logic signed [D_W-1:0]      t_dval;
    typedef logic signed [T_W-1:0]      t_tval;

    typedef struct packed {
        t_fix f_00;
        t_fix f_01;
        t_fix f_02;
        t_fix f_10;
        t_fix f_11;
        t_fix f_12;
        t_fix f_20;
        t_fix f_21;
        t_fix f_22;
    } t_in_item;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] energy;
        t_sval stress_00;
        t_sval stress_01;
        t_sval stress_02;
        t_sval stress_10;
        t_sval stress_11;
        t_sval stress_12;
        t_sval stress_20;
        t_sval stress_21;
        t_sval stress_22;
    } t_out_item;

    // Per-stage load enables from the pipeline control.
    typedef struct packed {
        logic [NUM_STG-1:0] en;
    } t_pipe_ctl;

endpackage

/* design/lese_stream_if.sv */
// ----------------------------------------------------------------------------
// lese_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface lese_stream_if #(
    parameter type t_payload = logic
);

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

/* design/linear_elastic_stress_energy_top.sv */
// ----------------------------------------------------------------------------
// linear_elastic_stress_energy_top
// Small-strain linear elastic stress and strain energy of one 3x3 deformation
// gradient per item, signed fixed point with 16 fraction bits (mu unsigned).
// The block is an eight-stage pipeline that takes one gradient per clock while
// the output side keeps up. The depth comes from splitting the wide products
// (squared strain entries, their sum times two mu, the squared trace times
// lambda) into partial products no wider than about 33 by 24 bits, with a
// register after each multiply. Every stage holds its item while the stage
// after it is full and stalled, so input transfers continue into empty stages
// while a finished result waits at the output. Input ready is a combinational
// function of output ready and the stage valid bits. The user must write the
// shear modulus and lambda through the configuration port only while no item
// is in flight; the block itself does not enforce this. They reset to mu = 1.0
// and lambda = 0.
// ----------------------------------------------------------------------------
module linear_elastic_stress_energy_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    lese_stream_if.sink                           i_in,
    lese_stream_if.source                         o_res,
    input  logic                                  i_cfg_we,
    input  logic [lese_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lese_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import lese_pkg::*;

    logic [MU_W-1:0]            r_lame_mu;
    logic signed [LAMBDA_W-1:0] r_lame_lambda;
    logic [MU2_W-1:0]           two_mu;

    logic [NUM_STG-1:0]         r_vld;
    logic [NUM_STG-1:0]         n_vld;
    logic [NUM_STG:0]           rdy;
    logic [NUM_STG-1:0]         w_hold;
    t_pipe_ctl                  ctl;

    t_dval                      d [9];
    t_tval                      t;
    t_sval                      stress [9];
    logic signed [ENERGY_W-1:0] energy;
    t_out_item                  n_out;
    t_out_item                  r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lame_mu     <= LAME_MU_RST;
            r_lame_lambda <= LAME_LAMBDA_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LAME_MU: begin
                    r_lame_mu <= i_cfg_data[MU_W-1:0];
                end
                CFG_LAME_LAMBDA: begin
                    r_lame_lambda <= $signed(i_cfg_data[LAMBDA_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    assign two_mu = {r_lame_mu, 1'b0};

    // A stage can load when it is empty or its item moves on this cycle.
    always_comb begin
        rdy[NUM_STG] = o_res.ready;
        for (int k = NUM_STG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        ctl.en = rdy[NUM_STG-1:0];
        n_vld  = {r_vld[NUM_STG-2:0], i_in.valid};
        w_hold = r_vld & ~rdy[NUM_STG:1];
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (rdy[NUM_STG-1:0] & n_vld) | (~rdy[NUM_STG-1:0] & r_vld);
        end
    end

    assign i_in.ready  = rdy[0];
    assign o_res.valid = r_vld[STG_OUT];
    assign o_res.payload = r_out;

    lese_strain u_strain (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_item (i_in.payload),
        .o_d    (d),
        .o_t    (t)
    );

    lese_stress u_stress (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_two_mu (two_mu),
        .i_lambda (r_lame_lambda),
        .i_d      (d),
        .i_t      (t),
        .o_stress (stress)
    );

    lese_energy u_energy (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_two_mu (two_mu),
        .i_lambda (r_lame_lambda),
        .i_d      (d),
        .i_t      (t),
        .o_energy (energy)
    );

    // Output register.
    always_comb begin
        n_out.energy    = energy;
        n_out.stress_00 = stress[0];
        n_out.stress_01 = stress[1];
        n_out.stress_02 = stress[2];
        n_out.stress_10 = stress[3];
        n_out.stress_11 = stress[4];
        n_out.stress_12 = stress[5];
        n_out.stress_20 = stress[6];
        n_out.stress_21 = stress[7];
        n_out.stress_22 = stress[8];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[STG_OUT]) begin
            r_out <= n_out;
        end
    end

    // Input is refused only when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_vld))
        else $error("input refused while a pipeline stage is empty");

    // A stage whose successor cannot take its item keeps it.
    a_stall_keeps_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_hold) |=> ((r_vld & $past(w_hold)) == $past(w_hold)))
        else $error("stalled pipeline stage dropped its item");

    // The stress of a symmetric strain is symmetric.
    a_stress_symmetric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_out.stress_01 == r_out.stress_10
                         && r_out.stress_02 == r_out.stress_20
                         && r_out.stress_12 == r_out.stress_21))
        else $error("stress result is not symmetric");

endmodule

/* design/lese_strain.sv */
// ----------------------------------------------------------------------------
// lese_strain
// First stage: doubled small strain 2*e = F + F^T - 2I and its trace.
// ----------------------------------------------------------------------------
module lese_strain (
    input  logic                i_clk,
    input  lese_pkg::t_pipe_ctl i_ctl,
    input  lese_pkg::t_in_item  i_item,
    output lese_pkg::t_dval     o_d [9],
    output lese_pkg::t_tval     o_t
);
    import lese_pkg::*;

    localparam logic signed [D_W-1:0] ONE_D   = D_W'(2 ** FRAC_BITS);
    localparam logic signed [T_W-1:0] THREE_T = T_W'(3 * (2 ** FRAC_BITS));

    t_fix  f [9];
    t_dval n_d [9];
    t_tval n_t;
    t_dval r_d [9];
    t_tval r_t;

    // Unpack the gradient in row-major order.
    always_comb begin
        f[0] = i_item.f_00;
        f[1] = i_item.f_01;
        f[2] = i_item.f_02;
        f[3] = i_item.f_10;
        f[4] = i_item.f_11;
        f[5] = i_item.f_12;
        f[6] = i_item.f_20;
        f[7] = i_item.f_21;
        f[8] = i_item.f_22;
    end

    // Diagonal entries are 2*(F_rr - 1), the others F_rc + F_cr.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r == c) begin
                    n_d[r*3+c] = (D_W'(f[r*3+r]) - ONE_D) <<< 1;
                end else begin
                    n_d[r*3+c] = D_W'(f[r*3+c]) + D_W'(f[c*3+r]);
                end
            end
        end
        n_t = ((T_W'(f[0]) + T_W'(f[4]) + T_W'(f[8])) - THREE_T) <<< 1;
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_STRAIN]) begin
            r_d <= n_d;
            r_t <= n_t;
        end
    end

    assign o_d = r_d;
    assign o_t = r_t;

endmodule

/* design/lese_stress.sv */
// ----------------------------------------------------------------------------
// lese_stress
// Stress path: 2*mu*e + lambda*tr(e)*I, built from split partial products,
// shifted, saturated and delayed to line up with the energy path.
// ----------------------------------------------------------------------------
module lese_stress (
    input  logic                                   i_clk,
    input  lese_pkg::t_pipe_ctl                    i_ctl,
    input  logic [lese_pkg::MU2_W-1:0]             i_two_mu,
    input  logic signed [lese_pkg::LAMBDA_W-1:0]   i_lambda,
    input  lese_pkg::t_dval                        i_d [9],
    input  lese_pkg::t_tval                        i_t,
    output lese_pkg::t_sval                        o_stress [9]
);
    import lese_pkg::*;

    localparam int TH_W  = T_W - SPLIT;
    localparam int DH_W  = D_W - SPLIT;
    localparam int PMH_W = MU2_W + 1 + DH_W;
    localparam int PML_W = MU2_W + SPLIT;
    localparam int PL_W  = LAMBDA_W + TH_W;
    localparam int MD_W  = PMH_W + SPLIT;
    localparam int LT_W  = PL_W + SPLIT;
    localparam int V_W   = ((MD_W > LT_W) ? MD_W : LT_W) + 1;
    localparam int SH    = FRAC_BITS + 1;
    localparam int DLY   = STG_OUT - STG_SUM3 - 1;

    logic signed [PMH_W-1:0] n_pmh [9];
    logic        [PML_W-1:0] n_pml [9];
    logic signed [PL_W-1:0]  n_plh;
    logic signed [PL_W-1:0]  n_pll;
    logic signed [PMH_W-1:0] r_pmh [9];
    logic        [PML_W-1:0] r_pml [9];
    logic signed [PL_W-1:0]  r_plh;
    logic signed [PL_W-1:0]  r_pll;

    logic signed [MD_W-1:0]  n_md [9];
    logic signed [LT_W-1:0]  n_lt;
    logic signed [MD_W-1:0]  r_md [9];
    logic signed [LT_W-1:0]  r_lt;

    logic signed [V_W-1:0]   v_sum [9];
    logic signed [V_W-1:0]   v_shr [9];
    t_sval                   n_s3 [9];
    t_sval                   r_s3 [9];
    t_sval                   r_dly [DLY][9];

    // Partial products: strain entries and trace split into high and low parts.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_pmh[k] = $signed({1'b0, i_two_mu}) * $signed(i_d[k][D_W-1:SPLIT]);
            n_pml[k] = i_two_mu * i_d[k][SPLIT-1:0];
        end
        n_plh = i_lambda * $signed(i_t[T_W-1:SPLIT]);
        n_pll = i_lambda * $signed({1'b0, i_t[SPLIT-1:0]});
    end

    // Recombine the partial products into the full products.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_md[k] = (MD_W'(r_pmh[k]) <<< SPLIT) + $signed(MD_W'(r_pml[k]));
        end
        n_lt = (LT_W'(r_plh) <<< SPLIT) + LT_W'(r_pll);
    end

    // Add the trace term on the diagonal, drop the fraction and saturate.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r == c) begin
                    v_sum[r*3+c] = V_W'(r_md[r*3+c]) + V_W'(r_lt);
                end else begin
                    v_sum[r*3+c] = V_W'(r_md[r*3+c]);
                end
            end
        end
        for (int k = 0; k < 9; k++) begin
            v_shr[k] = v_sum[k] >>> SH;
            if ((&v_shr[k][V_W-1:STRESS_W-1]) || !(|v_shr[k][V_W-1:STRESS_W-1])) begin
                n_s3[k] = v_shr[k][STRESS_W-1:0];
            end else if (v_shr[k][V_W-1]) begin
                n_s3[k] = STRESS_MIN;
            end else begin
                n_s3[k] = STRESS_MAX;
            end
        end
    end

    // Stage registers and the delay line that matches the energy path.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_PROD]) begin
            r_pmh <= n_pmh;
            r_pml <= n_pml;
            r_plh <= n_plh;
            r_pll <= n_pll;
        end
        if (i_ctl.en[STG_MERGE]) begin
            r_md <= n_md;
            r_lt <= n_lt;
        end
        if (i_ctl.en[STG_SUM3]) begin
            r_s3 <= n_s3;
        end
        if (i_ctl.en[STG_SUM3+1]) begin
            r_dly[0] <= r_s3;
        end
        for (int i = 1; i < DLY; i++) begin
            if (i_ctl.en[STG_SUM3+1+i]) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign o_stress = r_dly[DLY-1];

endmodule

/* design/lese_energy.sv */
// ----------------------------------------------------------------------------
// lese_energy
// Energy path: 2*mu*sum(d^2) + lambda*t^2 over partial products, then the
// fraction shift and saturation to the energy field.
// ----------------------------------------------------------------------------
module lese_energy (
    input  logic                                   i_clk,
    input  lese_pkg::t_pipe_ctl                    i_ctl,
    input  logic [lese_pkg::MU2_W-1:0]             i_two_mu,
    input  logic signed [lese_pkg::LAMBDA_W-1:0]   i_lambda,
    input  lese_pkg::t_dval                        i_d [9],
    input  lese_pkg::t_tval                        i_t,
    output logic signed [lese_pkg::ENERGY_W-1:0]   o_energy
);
    import lese_pkg::*;

    localparam int DH_W   = D_W - SPLIT;
    localparam int TH_W   = T_W - SPLIT;
    localparam int HH_W   = 2 * DH_W;
    localparam int HL_W   = DH_W + SPLIT + 1;
    localparam int LL_W   = 2 * SPLIT;
    localparam int THH_W  = 2 * TH_W;
    localparam int THL_W  = TH_W + SPLIT + 1;
    localparam int SQ_W   = 2 * D_W - 1;
    localparam int SQX_W  = SQ_W + 1;
    localparam int T2_W   = 2 * T_W - 2;
    localparam int T2X_W  = T2_W + 1;
    localparam int S3_W   = SQ_W + 2;
    localparam int SQS_W  = S3_W + 2;
    localparam int TP_W   = (T2_W + 2) / 3;
    localparam int TLP_W  = LAMBDA_W + TP_W + 1;
    localparam int TL_W   = LAMBDA_W + 3 * TP_W;
    localparam int QP_W   = (SQS_W + 2) / 3;
    localparam int MP_W   = MU2_W + QP_W;
    localparam int EN1_W  = MU2_W + 3 * QP_W;
    localparam int EN_W   = EN1_W + 1;
    localparam int ESH    = 2 * FRAC_BITS + 3;

    logic signed [HH_W-1:0]  n_hh [9];
    logic signed [HL_W-1:0]  n_hl [9];
    logic        [LL_W-1:0]  n_ll [9];
    logic signed [THH_W-1:0] n_thh;
    logic signed [THL_W-1:0] n_thl;
    logic        [LL_W-1:0]  n_tll;
    logic signed [HH_W-1:0]  r_hh [9];
    logic signed [HL_W-1:0]  r_hl [9];
    logic        [LL_W-1:0]  r_ll [9];
    logic signed [THH_W-1:0] r_thh;
    logic signed [THL_W-1:0] r_thl;
    logic        [LL_W-1:0]  r_tll;

    logic signed [SQX_W-1:0] sq_full [9];
    logic signed [T2X_W-1:0] t2_full;
    logic        [SQ_W-1:0]  r_sqv [9];
    logic        [T2_W-1:0]  r_t2;

    logic [3*TP_W-1:0]       t2_ext;
    logic        [S3_W-1:0]  n_s3 [3];
    logic signed [TLP_W-1:0] n_tlp [3];
    logic        [S3_W-1:0]  r_s3 [3];
    logic signed [TLP_W-1:0] r_tlp [3];

    logic        [SQS_W-1:0] n_sq;
    logic signed [TL_W-1:0]  n_tl2;
    logic        [SQS_W-1:0] r_sq;
    logic signed [TL_W-1:0]  r_tl2;

    logic [3*QP_W-1:0]       sq_ext;
    logic        [MP_W-1:0]  n_mp [3];
    logic        [MP_W-1:0]  r_mp [3];
    logic signed [TL_W-1:0]  r_tl2_d1;

    logic        [EN1_W-1:0] n_en1;
    logic        [EN1_W-1:0] r_en1;
    logic signed [TL_W-1:0]  r_tl2_d2;

    logic signed [EN_W-1:0]  en_sum;
    logic signed [EN_W-1:0]  en_shr;

    // Partial products of the squares of the strain entries and of the trace.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_hh[k] = $signed(i_d[k][D_W-1:SPLIT]) * $signed(i_d[k][D_W-1:SPLIT]);
            n_hl[k] = $signed(i_d[k][D_W-1:SPLIT]) * $signed({1'b0, i_d[k][SPLIT-1:0]});
            n_ll[k] = i_d[k][SPLIT-1:0] * i_d[k][SPLIT-1:0];
        end
        n_thh = $signed(i_t[T_W-1:SPLIT]) * $signed(i_t[T_W-1:SPLIT]);
        n_thl = $signed(i_t[T_W-1:SPLIT]) * $signed({1'b0, i_t[SPLIT-1:0]});
        n_tll = i_t[SPLIT-1:0] * i_t[SPLIT-1:0];
    end

    // Recombine into full squares: (h*2^S + l)^2 = h^2*2^2S + h*l*2^(S+1) + l^2.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            sq_full[k] = (SQX_W'(r_hh[k]) <<< (2 * SPLIT))
                       + (SQX_W'(r_hl[k]) <<< (SPLIT + 1))
                       + $signed(SQX_W'(r_ll[k]));
        end
        t2_full = (T2X_W'(r_thh) <<< (2 * SPLIT))
                + (T2X_W'(r_thl) <<< (SPLIT + 1))
                + $signed(T2X_W'(r_tll));
    end

    // Sum the squares in groups of three; lambda times slices of t^2.
    always_comb begin
        t2_ext = (3*TP_W)'(r_t2);
        for (int g = 0; g < 3; g++) begin
            n_s3[g] = S3_W'(r_sqv[3*g]) + S3_W'(r_sqv[3*g+1]) + S3_W'(r_sqv[3*g+2]);
            n_tlp[g] = i_lambda * $signed({1'b0, t2_ext[g*TP_W +: TP_W]});
        end
    end

    // Full sum of squares; lambda*t^2 from its slices.
    always_comb begin
        n_sq  = SQS_W'(r_s3[0]) + SQS_W'(r_s3[1]) + SQS_W'(r_s3[2]);
        n_tl2 = TL_W'(r_tlp[0])
              + (TL_W'(r_tlp[1]) <<< TP_W)
              + (TL_W'(r_tlp[2]) <<< (2 * TP_W));
    end

    // Two mu times slices of the sum of squares.
    always_comb begin
        sq_ext = (3*QP_W)'(r_sq);
        for (int g = 0; g < 3; g++) begin
            n_mp[g] = i_two_mu * sq_ext[g*QP_W +: QP_W];
        end
    end

    // Recombine the mu term.
    always_comb begin
        n_en1 = EN1_W'(r_mp[0])
              + (EN1_W'(r_mp[1]) << QP_W)
              + (EN1_W'(r_mp[2]) << (2 * QP_W));
    end

    // Add both terms, drop the fraction and saturate.
    always_comb begin
        en_sum = $signed({1'b0, r_en1}) + EN_W'(r_tl2_d2);
        en_shr = en_sum >>> ESH;
        if ((&en_shr[EN_W-1:ENERGY_W-1]) || !(|en_shr[EN_W-1:ENERGY_W-1])) begin
            o_energy = en_shr[ENERGY_W-1:0];
        end else if (en_shr[EN_W-1]) begin
            o_energy = ENERGY_MIN;
        end else begin
            o_energy = ENERGY_MAX;
        end
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_PROD]) begin
            r_hh  <= n_hh;
            r_hl  <= n_hl;
            r_ll  <= n_ll;
            r_thh <= n_thh;
            r_thl <= n_thl;
            r_tll <= n_tll;
        end
        if (i_ctl.en[STG_MERGE]) begin
            for (int k = 0; k < 9; k++) begin
                r_sqv[k] <= sq_full[k][SQ_W-1:0];
            end
            r_t2 <= t2_full[T2_W-1:0];
        end
        if (i_ctl.en[STG_SUM3]) begin
            r_s3  <= n_s3;
            r_tlp <= n_tlp;
        end
        if (i_ctl.en[STG_SUM9]) begin
            r_sq  <= n_sq;
            r_tl2 <= n_tl2;
        end
        if (i_ctl.en[STG_MU]) begin
            r_mp     <= n_mp;
            r_tl2_d1 <= r_tl2;
        end
        if (i_ctl.en[STG_EN1]) begin
            r_en1    <= n_en1;
            r_tl2_d2 <= r_tl2_d1;
        end
    end

endmodule

/* tb/lese_response_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lese_response_checker
// Watches the gradient and result channels and the configuration port of the
// linear elastic stress and energy block. Each gradient transfer is turned
// into the expected energy and stress with exact wide arithmetic, and each
// result transfer is compared field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module lese_response_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_grad_valid,
    input  logic                            i_grad_ready,
    input  lese_pkg::t_in_item              i_grad,
    input  logic                            i_resp_valid,
    input  logic                            i_resp_ready,
    input  lese_pkg::t_out_item             i_resp,
    input  logic                            i_cfg_we,
    input  logic [lese_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lese_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_in_flight
);
    import lese_pkg::*;

    typedef logic signed [127:0] t_wide;

    // Local copy of the material registers.
    logic [MU_W-1:0]            shear_mod;
    logic signed [LAMBDA_W-1:0] lame_first;

    // Responses owed by the block, oldest first.
    t_out_item awaited_resp [$];
    int        n_bad = 0;

    // Clamp a wide signed value to a signed field of the given width.
    function automatic t_wide clamp_signed(t_wide x, int bits);
        t_wide top_lim;
        top_lim = (t_wide'(1) <<< (bits - 1)) - t_wide'(1);
        if (x > top_lim) return top_lim;
        if (x < -top_lim - t_wide'(1)) return -top_lim - t_wide'(1);
        return x;
    endfunction

    // Energy and stress of one gradient under the given mu and lambda.
    // The doubled strain keeps every value an exact integer, and all sums
    // stay far below 128 bits, so the only rounding is the final shift.
    function automatic t_out_item elastic_response(t_in_item g,
                                                   logic [MU_W-1:0] mu,
                                                   logic signed [LAMBDA_W-1:0] lam);
        t_fix                       fm [9];
        t_wide                      d [9];
        t_wide                      a, b, tr, sq, two_mu, lam_w, num;
        logic signed [STRESS_W-1:0] st [9];
        logic signed [ENERGY_W-1:0] en;
        int                         r, c;
        fm = '{g.f_00, g.f_01, g.f_02, g.f_10, g.f_11, g.f_12, g.f_20, g.f_21, g.f_22};
        two_mu = {96'd0, mu, 1'b0};
        lam_w  = lam;
        tr = '0;
        sq = '0;
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
                a = fm[r * 3 + c];
                b = fm[c * 3 + r];
                if (r == c) begin
                    d[r * 3 + c] = (a - (t_wide'(1) <<< FRAC_BITS)) <<< 1;
                    tr = tr + d[r * 3 + c];
                end else begin
                    d[r * 3 + c] = a + b;
                end
                sq = sq + d[r * 3 + c] * d[r * 3 + c];
            end
        end

        num = clamp_signed((two_mu * sq + lam_w * tr * tr) >>> (2 * FRAC_BITS + 3),
                           ENERGY_W);
        en = num[ENERGY_W-1:0];

        // Lambda times the trace only lands on the diagonal.
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
                num = two_mu * d[r * 3 + c];
                if (r == c) num = num + lam_w * tr;
                num = clamp_signed(num >>> (FRAC_BITS + 1), STRESS_W);
                st[r * 3 + c] = num[STRESS_W-1:0];
            end
        end
        return {en, st[0], st[1], st[2], st[3], st[4], st[5], st[6], st[7], st[8]};
    endfunction

    task automatic compare_field(string name, logic signed [63:0] want,
                                 logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_bad++;
        end
    endtask

    // Track configuration, queue expectations and check result transfers.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            shear_mod  <= LAME_MU_RST;
            lame_first <= LAME_LAMBDA_RST;
            awaited_resp.delete();
        end else begin
            if (i_resp_valid && i_resp_ready) begin
                if (awaited_resp.size() == 0) begin
                    $error("Result transfer with no gradient awaiting it");
                    n_bad++;
                end else begin
                    want = awaited_resp.pop_front();
                    compare_field("energy",    want.energy,    i_resp.energy);
                    compare_field("stress_00", want.stress_00, i_resp.stress_00);
                    compare_field("stress_01", want.stress_01, i_resp.stress_01);
                    compare_field("stress_02", want.stress_02, i_resp.stress_02);
                    compare_field("stress_10", want.stress_10, i_resp.stress_10);
                    compare_field("stress_11", want.stress_11, i_resp.stress_11);
                    compare_field("stress_12", want.stress_12, i_resp.stress_12);
                    compare_field("stress_20", want.stress_20, i_resp.stress_20);
                    compare_field("stress_21", want.stress_21, i_resp.stress_21);
                    compare_field("stress_22", want.stress_22, i_resp.stress_22);
                end
            end
            if (i_grad_valid && i_grad_ready) begin
                awaited_resp.push_back(elastic_response(i_grad, shear_mod, lame_first));
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LAME_MU) begin
                    shear_mod <= i_cfg_data[MU_W-1:0];
                end else if (i_cfg_idx == CFG_LAME_LAMBDA) begin
                    lame_first <= i_cfg_data;
                end
            end
        end
        o_mismatches <= n_bad;
        o_in_flight  <= awaited_resp.size();
    end

endmodule

/* tb/tb_linear_elastic_stress_energy_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_elastic_stress_energy_top
// Drives deformation gradients into the linear elastic stress and energy
// block under a series of material settings, from corner cases to random
// streams, with random idling on both channels. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_linear_elastic_stress_energy_top;
    import lese_pkg::*;

    localparam int NUM_RAND_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int STALL_MAX       = 14;
    localparam int DRAIN_CYCLES    = 2 * NUM_STG + 4;
    localparam int WATCHDOG_LIMIT  = 1000;

    localparam t_fix FIX_ONE = t_fix'(1 <<< FRAC_BITS);
    localparam t_fix FIX_MAX = 32'sh7FFFFFFF;
    localparam t_fix FIX_MIN = 32'sh80000000;

    // Kinds of random gradients.
    typedef enum int {
        GRAD_NEAR_IDENTITY,
        GRAD_MODERATE,
        GRAD_ANY,
        GRAD_CORNER
    } t_grad_kind;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  smooth_flow = 1'b0;
    int                    mismatches;
    int                    in_flight;
    int                    quiet_cycles = 0;

    lese_stream_if #(.t_payload(t_in_item))  grad_if ();
    lese_stream_if #(.t_payload(t_out_item)) resp_if ();

    linear_elastic_stress_energy_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (grad_if),
        .o_res      (resp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lese_response_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_grad_valid (grad_if.valid),
        .i_grad_ready (grad_if.ready),
        .i_grad       (grad_if.payload),
        .i_resp_valid (resp_if.valid),
        .i_resp_ready (resp_if.ready),
        .i_resp       (resp_if.payload),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_in_flight  (in_flight)
    );

    always #5 clk = ~clk;

    // Idle cycles before the next transfer; none while the flow is smooth.
    function automatic int draw_wait();
        return smooth_flow ? 0 : $urandom_range(STALL_MAX);
    endfunction

    function automatic t_fix draw_entry(bit on_diag, t_grad_kind kind);
        t_fix v;
        case (kind)
            GRAD_NEAR_IDENTITY: begin
                v = int'($urandom_range(32768)) - 16384;
                if (on_diag) v = v + FIX_ONE;
            end
            GRAD_MODERATE: v = int'($urandom_range(1 << 21)) - (1 << 20);
            GRAD_ANY:      v = $urandom();
            default: begin
                case ($urandom_range(5))
                    0:       v = FIX_MAX;
                    1:       v = FIX_MIN;
                    2:       v = '0;
                    3:       v = -1;
                    4:       v = FIX_ONE;
                    default: v = $urandom();
                endcase
            end
        endcase
        return v;
    endfunction

    // Small deformations near identity in 40 percent of draws, plus moderate, wide and corner values.
    function automatic t_in_item draw_grad();
        t_fix       e [9];
        t_grad_kind kind;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)      kind = GRAD_NEAR_IDENTITY;
        else if (roll < 65) kind = GRAD_MODERATE;
        else if (roll < 85) kind = GRAD_ANY;
        else                kind = GRAD_CORNER;
        for (int k = 0; k < 9; k++) e[k] = draw_entry(k % 4 == 0, kind);
        return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    endfunction

    // Present one gradient and return at the edge of its transfer.
    task automatic send_grad(t_in_item g);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            grad_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        grad_if.valid   <= 1'b1;
        grad_if.payload <= g;
        do @(posedge clk); while (!grad_if.ready);
    endtask

    // Stop sending and wait until every result has come back.
    task automatic wait_idle();
        grad_if.valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
    endtask

    // Write mu, then lambda, through the configuration port.
    task automatic write_lame(logic [CFG_DATA_W-1:0] mu_word,
                              logic [CFG_DATA_W-1:0] lambda_word);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LAME_MU;
        cfg_data <= mu_word;
        @(posedge clk);
        cfg_idx  <= CFG_LAME_LAMBDA;
        cfg_data <= lambda_word;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Result side: random stall before each transfer.
    initial begin
        int stall;
        resp_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                resp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            resp_if.ready <= 1'b1;
            do @(posedge clk); while (!resp_if.valid);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if (!rst_n || (grad_if.valid && grad_if.ready) || (resp_if.valid && resp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: corner gradients under three settings, then random phases.
    initial begin
        t_in_item              corner [8];
        logic [CFG_DATA_W-1:0] mu_word, lambda_word;
        grad_if.valid   <= 1'b0;
        grad_if.payload <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_LAME_MU;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        corner[0] = {FIX_ONE, t_fix'(0), t_fix'(0), t_fix'(0), FIX_ONE, t_fix'(0),
                     t_fix'(0), t_fix'(0), FIX_ONE};
        corner[1] = '0;
        corner[2] = {9{FIX_MAX}};
        corner[3] = {9{FIX_MIN}};
        corner[4] = {FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MIN,
                     FIX_MIN, FIX_MIN, FIX_MAX};
        // Simple shear and uniaxial stretch by one half.
        corner[5] = {FIX_ONE, t_fix'(32768), t_fix'(0), t_fix'(0), FIX_ONE, t_fix'(0),
                     t_fix'(0), t_fix'(0), FIX_ONE};
        corner[6] = {t_fix'(98304), t_fix'(0), t_fix'(0), t_fix'(0), FIX_ONE, t_fix'(0),
                     t_fix'(0), t_fix'(0), FIX_ONE};
        corner[7] = {9{t_fix'(-1)}};

        // Reset values first, then the register extremes, then zero mu with
        // a negative lambda so that the energy goes negative.
        for (int p = 0; p < 3; p++) begin
            if (p == 1) write_lame(32'h7FFF_FFFF, 32'h8000_0000);
            if (p == 2) write_lame(32'h8000_0000, 32'hFFFF_0000);
            foreach (corner[k]) send_grad(corner[k]);
            wait_idle();
        end

        for (int p = 0; p < NUM_RAND_PHASES; p++) begin
            case (p)
                0: begin
                    mu_word     = 32'hFFFF_FFFF;
                    lambda_word = 32'h7FFF_FFFF;
                end
                1: begin
                    mu_word     = 32'h0000_0001;
                    lambda_word = 32'h8000_0000;
                end
                default: begin
                    if ($urandom_range(1)) mu_word = $urandom();
                    else mu_word = {1'($urandom_range(1)),
                                    31'($urandom_range(1 << 20, 1 << 12))};
                    if ($urandom_range(1)) lambda_word = $urandom();
                    else lambda_word = int'($urandom_range(1 << 21)) - (1 << 20);
                end
            endcase
            write_lame(mu_word, lambda_word);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(63) == 0) smooth_flow = !smooth_flow;
                send_grad(draw_grad());
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && in_flight == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
